// File: hdl/plic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plic_pkg: shared definitions for the platform interrupt controller
// Map constants, geometry of the bitmaps and the priority store, bus
// transaction types and the control/status bundles between the parts.
// ----------------------------------------------------------------------------
package plic_pkg;

    // Geometry
    localparam int SOURCES       = 32;
    localparam int CONTEXTS      = 2;
    localparam int PRIORITY_BITS = 3;

    localparam int WORDS    = (SOURCES + 31) / 32;
    localparam int BITMAP_W = WORDS * 32;
    localparam int SLOT_W   = $clog2(BITMAP_W);
    localparam int WORD_IW  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CTX_IW   = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;

    // Priority store: rows of CHUNK entries, one row compared per cycle
    localparam int CHUNK   = 8;
    localparam int CHUNK_W = $clog2(CHUNK);
    localparam int NROWS   = (SOURCES + CHUNK - 1) / CHUNK;
    localparam int ROW_W   = (NROWS > 1) ? $clog2(NROWS) : 1;
    localparam int SLOTS   = NROWS * CHUNK;

    // Register map
    localparam logic [25:0] PEND_BASE     = 26'h000_1000;
    localparam logic [25:0] EN_BASE       = 26'h000_2000;
    localparam logic [25:0] CTX_BASE      = 26'h020_0000;
    localparam logic [11:0] REG_THRESHOLD = 12'h000;
    localparam logic [11:0] REG_CLAIM     = 12'h004;

    // Operation codes
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_WRITE  = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [25:0] address;
        logic [31:0] write_data;
        logic [31:0] request_lines;
    } plic_in_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [1:0]  context_interrupt;
    } plic_out_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic             take;
        logic             scan_init;
        logic             scan_step;
        logic [ROW_W-1:0] step_row;
        logic [ROW_W-1:0] rd_row;
        logic             rd_bus;
        logic             access;
        logic             capture;
        logic             result_load;
    } plic_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;
    } plic_sts_t;

    // Implemented sources within bitmap word w, source zero excluded
    function automatic logic [31:0] word_mask(input int w);
        int          base;
        logic [31:0] m;
        base = w * 32;
        if (base >= SOURCES) begin
            m = '0;
        end else if (SOURCES - base >= 32) begin
            m = '1;
        end else begin
            m = (32'd1 << (SOURCES - base)) - 32'd1;
        end
        if (w == 0) begin
            m[0] = 1'b0;
        end
        return m;
    endfunction

    // Sources that a request line reaches
    function automatic logic [BITMAP_W-1:0] req_mask();
        logic [BITMAP_W-1:0] m;
        m = '0;
        for (int s = 1; s < BITMAP_W; s++) begin
            if (s < 32 && s < SOURCES) begin
                m[s] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage

// File: hdl/platform_interrupt_controller_unit.sv
// Sequence: from the input accept the sequencer loads, scans all NROWS = SOURCES/8 (4) rows
// of the priority store, one row of eight sources per cycle, performs the access, scans again
// and loads the result once the output register is free; the next transaction waits for that.
// Reset: aresetn is synchronous, active low; it clears the sequencer, all bitmaps,
// thresholds and output valid; priority entries read zero until written.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// platform_interrupt_controller_unit: memory-mapped platform interrupt controller
// Samples request lines into a gateway, serves priority, pending, enable,
// threshold and claim/complete accesses, and drives one line per context.
// ----------------------------------------------------------------------------
module platform_interrupt_controller_unit
    import plic_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  plic_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output plic_out_t m_data
);

    plic_cmd_t cmd;
    plic_sts_t sts;

    // Sequence each transaction
    plic_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Hold state and compute results
    plic_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule

// File: hdl/plic_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plic_ctrl: transaction sequencer
// Steps each transaction through sampling, the pre-access arbitration scan,
// the bus access, the post-access scan and the result hand-off.
// ----------------------------------------------------------------------------
module plic_ctrl
    import plic_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  plic_sts_t sts,
    output plic_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOAD   = 3'd1;
    localparam logic [2:0] ST_SCAN1  = 3'd2;
    localparam logic [2:0] ST_ACCESS = 3'd3;
    localparam logic [2:0] ST_POST   = 3'd4;
    localparam logic [2:0] ST_SCAN2  = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [ROW_W-1:0] cnt_reg, cnt_next;
    logic             last_row;

    assign last_row = (cnt_reg == ROW_W'(NROWS - 1));

    // Decode state into commands
    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        s_ready         = 1'b0;
        cmd             = '0;
        cmd.step_row    = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.take   = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.scan_init = 1'b1;
                cnt_next      = '0;
                state_next    = ST_SCAN1;
            end
            ST_SCAN1: begin
                cmd.scan_step = 1'b1;
                if (last_row) begin
                    state_next = ST_ACCESS;
                end else begin
                    cnt_next   = cnt_reg + ROW_W'(1);
                    cmd.rd_row = cnt_reg + ROW_W'(1);
                end
            end
            ST_ACCESS: begin
                cmd.access = 1'b1;
                cmd.rd_bus = 1'b1;
                state_next = ST_POST;
            end
            ST_POST: begin
                cmd.capture   = 1'b1;
                cmd.scan_init = 1'b1;
                cnt_next      = '0;
                state_next    = ST_SCAN2;
            end
            ST_SCAN2: begin
                cmd.scan_step = 1'b1;
                if (last_row) begin
                    state_next = ST_FINISH;
                end else begin
                    cnt_next   = cnt_reg + ROW_W'(1);
                    cmd.rd_row = cnt_reg + ROW_W'(1);
                end
            end
            ST_FINISH: begin
                // Hold until the output register is free
                if (sts.out_free) begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// File: hdl/plic_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plic_dp: interrupt controller datapath
// Holds the priority store, pending/claimed/enable bitmaps and thresholds,
// the per-context arbitration registers, address decode and result register.
// ----------------------------------------------------------------------------
module plic_dp
    import plic_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  plic_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output plic_out_t m_data,
    input  plic_cmd_t cmd,
    output plic_sts_t sts
);

    // Transaction and architectural state
    plic_in_t                item_reg;
    logic [BITMAP_W-1:0]     pending_reg;
    logic [BITMAP_W-1:0]     claimed_reg;
    logic [BITMAP_W-1:0]     enable_reg    [CONTEXTS];
    logic [PRIORITY_BITS-1:0] threshold_reg [CONTEXTS];

    // Priority store and its read port
    logic [PRIORITY_BITS-1:0] prio_mem      [NROWS][CHUNK];
    logic [SLOTS-1:0]         prio_valid_reg;
    logic [PRIORITY_BITS-1:0] rd_row_reg    [CHUNK];
    logic [ROW_W-1:0]         rd_addr;

    // Arbitration
    logic [PRIORITY_BITS-1:0] level_reg [CONTEXTS];
    logic [SLOT_W-1:0]        best_reg  [CONTEXTS];
    logic [PRIORITY_BITS-1:0] step_lvl  [CONTEXTS];
    logic [SLOT_W-1:0]        step_best [CONTEXTS];

    // Result
    logic [31:0] rdata_reg;
    logic        prio_rd_reg;
    plic_out_t   out_reg;
    logic        m_valid_reg;
    logic [1:0]  irq;

    // Address decode
    logic [25:0]        addr_a;
    logic               is_rd, is_wr;
    logic               in_prio, in_pend, in_en;
    logic [9:0]         prio_src;
    logic               prio_ok;
    logic [ROW_W-1:0]   prio_row;
    logic [CHUNK_W-1:0] prio_col;
    logic [9:0]         pend_w;
    logic               pend_ok;
    logic [25:0]        en_off;
    logic [13:0]        en_ctx;
    logic [4:0]         en_w;
    logic               en_ok;
    logic [25:0]        cx_off;
    logic [13:0]        cx_ctx;
    logic [11:0]        cx_reg;
    logic               cx_ok;
    logic [CTX_IW-1:0]  en_idx, cx_idx;
    logic [WORD_IW-1:0] pend_widx, en_widx;
    logic [31:0]        wdata;
    logic               cpl_ok;
    logic [SLOT_W-1:0]  cpl_idx;

    assign addr_a    = {item_reg.address[25:2], 2'b00};
    assign is_rd     = (item_reg.operation == OP_READ);
    assign is_wr     = (item_reg.operation == OP_WRITE);
    assign wdata     = item_reg.write_data;
    assign in_prio   = (addr_a < PEND_BASE);
    assign in_pend   = (addr_a < EN_BASE);
    assign in_en     = (addr_a < CTX_BASE);
    assign prio_src  = addr_a[11:2];
    assign prio_ok   = (prio_src != 10'd0) && (prio_src < SOURCES);
    assign prio_row  = prio_src[CHUNK_W +: ROW_W];
    assign prio_col  = prio_src[CHUNK_W-1:0];
    assign pend_w    = addr_a[11:2];
    assign pend_ok   = (pend_w < WORDS);
    assign pend_widx = pend_w[WORD_IW-1:0];
    assign en_off    = addr_a - EN_BASE;
    assign en_ctx    = en_off[20:7];
    assign en_w      = en_off[6:2];
    assign en_ok     = (en_ctx < CONTEXTS) && (en_w < WORDS);
    assign en_idx    = en_ctx[CTX_IW-1:0];
    assign en_widx   = en_w[WORD_IW-1:0];
    assign cx_off    = addr_a - CTX_BASE;
    assign cx_ctx    = cx_off[25:12];
    assign cx_reg    = cx_off[11:0];
    assign cx_ok     = (cx_ctx < CONTEXTS);
    assign cx_idx    = cx_ctx[CTX_IW-1:0];
    assign cpl_idx   = wdata[SLOT_W-1:0];
    assign cpl_ok    = (wdata != 32'd0) && (wdata < SOURCES) && enable_reg[cx_idx][cpl_idx];

    // Select the priority store row to read
    assign rd_addr = cmd.rd_bus ? (prio_ok ? prio_row : '0) : cmd.rd_row;

    // Write and read the priority store
    always_ff @(posedge aclk) begin
        if (cmd.access && is_wr && in_prio && prio_ok) begin
            prio_mem[prio_row][prio_col] <= wdata[PRIORITY_BITS-1:0];
        end
        for (int j = 0; j < CHUNK; j++) begin
            rd_row_reg[j] <= prio_valid_reg[{rd_addr, CHUNK_W'(j)}] ?
                             prio_mem[rd_addr][j] : '0;
        end
    end

    // Track written priority entries; unwritten ones read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prio_valid_reg <= '0;
        end else if (cmd.access && is_wr && in_prio && prio_ok) begin
            prio_valid_reg[{prio_row, prio_col}] <= 1'b1;
        end
    end

    // Compare one row of sources per context
    always_comb begin
        for (int c = 0; c < CONTEXTS; c++) begin
            step_lvl[c]  = level_reg[c];
            step_best[c] = best_reg[c];
            for (int j = 0; j < CHUNK; j++) begin
                if ((int'({cmd.step_row, CHUNK_W'(j)}) < SOURCES) &&
                    ({cmd.step_row, CHUNK_W'(j)} != '0) &&
                    pending_reg[SLOT_W'({cmd.step_row, CHUNK_W'(j)})] &&
                    enable_reg[c][SLOT_W'({cmd.step_row, CHUNK_W'(j)})] &&
                    (rd_row_reg[j] > step_lvl[c])) begin
                    step_lvl[c]  = rd_row_reg[j];
                    step_best[c] = SLOT_W'({cmd.step_row, CHUNK_W'(j)});
                end
            end
        end
    end

    // Hold the running winner per context
    always_ff @(posedge aclk) begin
        for (int c = 0; c < CONTEXTS; c++) begin
            if (cmd.scan_init) begin
                level_reg[c] <= threshold_reg[c];
                best_reg[c]  <= '0;
            end else if (cmd.scan_step) begin
                level_reg[c] <= step_lvl[c];
                best_reg[c]  <= step_best[c];
            end
        end
    end

    // Latch the transaction
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            item_reg <= s_data;
        end
    end

    // Update bitmaps and thresholds: sample on take, bus access after scan
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
            claimed_reg <= '0;
            for (int c = 0; c < CONTEXTS; c++) begin
                enable_reg[c]    <= '0;
                threshold_reg[c] <= '0;
            end
        end else if (cmd.take) begin
            pending_reg <= pending_reg |
                           (BITMAP_W'(s_data.request_lines) & req_mask() & ~claimed_reg);
        end else if (cmd.access && !in_prio && !in_pend) begin
            if (in_en) begin
                if (is_wr && en_ok) begin
                    enable_reg[en_idx][en_widx*32 +: 32] <= wdata & word_mask(int'(en_widx));
                end
            end else if (cx_ok) begin
                if (cx_reg == REG_THRESHOLD) begin
                    if (is_wr) begin
                        threshold_reg[cx_idx] <= wdata[PRIORITY_BITS-1:0];
                    end
                end else if (cx_reg == REG_CLAIM) begin
                    if (is_rd && (best_reg[cx_idx] != '0)) begin
                        pending_reg[best_reg[cx_idx]] <= 1'b0;
                        claimed_reg[best_reg[cx_idx]] <= 1'b1;
                    end else if (is_wr && cpl_ok) begin
                        claimed_reg[cpl_idx] <= 1'b0;
                    end
                end
            end
        end
    end

    // Form read data
    always_ff @(posedge aclk) begin
        if (cmd.access) begin
            prio_rd_reg <= is_rd && in_prio && prio_ok;
            if (is_rd && !in_prio && in_pend && pend_ok) begin
                rdata_reg <= pending_reg[pend_widx*32 +: 32] &
                             word_mask(int'(pend_widx));
            end else if (is_rd && !in_pend && in_en && en_ok) begin
                rdata_reg <= enable_reg[en_idx][en_widx*32 +: 32];
            end else if (is_rd && !in_en && cx_ok && (cx_reg == REG_THRESHOLD)) begin
                rdata_reg <= 32'(threshold_reg[cx_idx]);
            end else if (is_rd && !in_en && cx_ok && (cx_reg == REG_CLAIM)) begin
                rdata_reg <= 32'(best_reg[cx_idx]);
            end else begin
                rdata_reg <= '0;
            end
        end else if (cmd.capture && prio_rd_reg) begin
            rdata_reg <= 32'(rd_row_reg[prio_col]);
        end
    end

    // Interrupt lines from the post-access scan
    always_comb begin
        irq = '0;
        for (int k = 0; k < 2; k++) begin
            if (k < CONTEXTS) begin
                irq[k] = (best_reg[CTX_IW'(k)] != '0);
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (cmd.result_load) begin
            out_reg.read_data         <= rdata_reg;
            out_reg.context_interrupt <= irq;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.result_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_data       = out_reg;
    assign sts.out_free = !m_valid_reg || m_ready;

endmodule

// File: sim/platform_interrupt_controller_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// platform_interrupt_controller_unit_test: self-checking bench for the PLIC unit
// Runs a short table of directed bus accesses, then a long random mix of
// priority, enable, threshold, claim and completion traffic over changing
// request lines. Each accepted transaction is run through a behavioral copy of
// the controller; results are matched in order, field by field.
// ----------------------------------------------------------------------------
module platform_interrupt_controller_unit_test;
    import plic_pkg::*;

    localparam int          CLK_PERIOD      = 4;
    localparam int          RANDOM_ITEMS    = 1250;
    localparam int          HOLD_OFF_CYCLES = 300;
    localparam int          IDLE_LIMIT      = 2000;
    localparam int          DRAIN_CYCLES    = 2 * (2 * NROWS + 5);
    localparam logic [1:0]  OP_SPARE        = 2'd3;
    localparam int unsigned PRIO_MAX        = (1 << PRIORITY_BITS) - 1;
    localparam logic [31:0] LIVE_MASK =
        ((SOURCES >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << SOURCES) - 64'd1)) & 32'hFFFF_FFFE;

    typedef struct {
        plic_in_t  stim;
        bit        fixed;
        plic_out_t resp;
    } directed_case_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    plic_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    plic_out_t m_data;

    // Behavioral copy of the controller state
    logic [PRIORITY_BITS-1:0] prio_tab [SOURCES];
    logic [31:0]              pend_word;
    logic [31:0]              enable_word [CONTEXTS];
    logic [PRIORITY_BITS-1:0] thr_tab [CONTEXTS];
    logic [31:0]              claim_word;

    plic_out_t      expected_responses [$];
    directed_case_t directed_cases [$];
    int             error_count      = 0;
    int             quiet_cycles     = 0;
    bit             hold_off_pending = 1'b0;

    platform_interrupt_controller_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic logic [25:0] priority_addr(input int unsigned src);
        return 26'(src * 4);
    endfunction

    function automatic logic [25:0] enable_addr(input int unsigned ctx, input int unsigned w);
        return EN_BASE + 26'(ctx * 128 + w * 4);
    endfunction

    function automatic logic [25:0] context_addr(input int unsigned ctx, input logic [11:0] off);
        return CTX_BASE + 26'(ctx * 4096) + 26'(off);
    endfunction

    // Highest-priority pending, enabled source above threshold; lowest id wins ties
    function automatic int unsigned winning_source(input int unsigned ctx);
        int unsigned              best;
        logic [PRIORITY_BITS-1:0] level;
        best  = 0;
        level = thr_tab[ctx];
        for (int s = 1; s < SOURCES; s++) begin
            if (pend_word[s] && enable_word[ctx][s] && prio_tab[s] > level) begin
                level = prio_tab[s];
                best  = s;
            end
        end
        return best;
    endfunction

    // Apply one transaction to the state copy and return the response it yields
    function automatic plic_out_t predict_response(input plic_in_t item);
        logic [25:0] addr;
        logic [25:0] off;
        logic [31:0] wd;
        bit          is_rd;
        bit          is_wr;
        int unsigned idx;
        int unsigned ctx;
        int unsigned win;
        plic_out_t   resp;
        addr  = item.address & ~26'd3;
        wd    = item.write_data;
        is_rd = (item.operation == OP_READ);
        is_wr = (item.operation == OP_WRITE);
        resp  = '0;

        // gateway: a line pends only a source that is neither pending nor claimed
        pend_word = pend_word | (item.request_lines & LIVE_MASK & ~claim_word);

        if (is_rd || is_wr) begin
            if (addr < PEND_BASE) begin
                idx = 32'(addr >> 2);
                if (idx != 0 && idx < SOURCES) begin
                    if (is_rd) resp.read_data = 32'(prio_tab[idx]);
                    else prio_tab[idx] = wd[PRIORITY_BITS-1:0];
                end
            end else if (addr < EN_BASE) begin
                idx = 32'((addr - PEND_BASE) >> 2);
                if (is_rd && idx < WORDS) resp.read_data = pend_word & LIVE_MASK;
            end else if (addr < CTX_BASE) begin
                off = addr - EN_BASE;
                idx = 32'(off[6:2]);
                ctx = 32'(off >> 7);
                if (ctx < CONTEXTS && idx < WORDS) begin
                    if (is_rd) resp.read_data = enable_word[ctx];
                    else enable_word[ctx] = wd & LIVE_MASK;
                end
            end else begin
                off = addr - CTX_BASE;
                ctx = 32'(off >> 12);
                if (ctx < CONTEXTS) begin
                    if (off[11:0] == REG_THRESHOLD) begin
                        if (is_rd) resp.read_data = 32'(thr_tab[ctx]);
                        else thr_tab[ctx] = wd[PRIORITY_BITS-1:0];
                    end else if (off[11:0] == REG_CLAIM) begin
                        if (is_rd) begin
                            win = winning_source(ctx);
                            if (win != 0) begin
                                pend_word[win]  = 1'b0;
                                claim_word[win] = 1'b1;
                            end
                            resp.read_data = win;
                        end else if (wd != 0 && wd < SOURCES &&
                                     enable_word[ctx][wd[SLOT_W-1:0]]) begin
                            claim_word[wd[SLOT_W-1:0]] = 1'b0;
                        end
                    end
                end
            end
        end

        for (int c = 0; c < CONTEXTS && c < 2; c++) begin
            resp.context_interrupt[c] = (winning_source(c) != 0);
        end
        return resp;
    endfunction

    // Build one random transaction, weighted toward claim/complete traffic
    function automatic plic_in_t random_item();
        plic_in_t    item;
        int unsigned pick;
        int unsigned ctx;
        int unsigned src;
        int unsigned w;
        item.operation  = OP_SAMPLE;
        item.address    = 26'($urandom);
        item.write_data = $urandom;
        case ($urandom_range(0, 3))
            0:       item.request_lines = $urandom;
            1:       item.request_lines = $urandom & $urandom & $urandom;
            2:       item.request_lines = 32'd1 << $urandom_range(0, 31);
            default: item.request_lines = '0;
        endcase
        pick = $urandom_range(0, 99);
        ctx  = ($urandom_range(0, 9) == 0) ? $urandom_range(CONTEXTS, 63)
                                            : $urandom_range(0, CONTEXTS - 1);
        src  = ($urandom_range(0, 15) == 0) ? $urandom_range(SOURCES, 1023)
                                             : $urandom_range(0, SOURCES - 1);
        w    = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 31) : 0;

        if (pick < 14) begin
            item.operation = ($urandom_range(0, 7) == 0) ? OP_SPARE : OP_SAMPLE;
        end else if (pick < 28) begin
            item.operation = OP_WRITE;
            item.address   = priority_addr(src);
            if ($urandom_range(0, 3) != 0) item.write_data = $urandom_range(0, PRIO_MAX);
        end else if (pick < 33) begin
            item.operation = OP_READ;
            item.address   = priority_addr(src);
        end else if (pick < 38) begin
            item.operation = ($urandom_range(0, 3) == 0) ? OP_WRITE : OP_READ;
            item.address   = PEND_BASE + 26'(($urandom_range(0, 3) == 0) ?
                                              $urandom_range(0, 1023) * 4 : 0);
        end else if (pick < 48) begin
            item.operation = ($urandom_range(0, 1) == 0) ? OP_WRITE : OP_READ;
            item.address   = enable_addr(ctx, w);
        end else if (pick < 53) begin
            item.operation = ($urandom_range(0, 1) == 0) ? OP_WRITE : OP_READ;
            item.address   = context_addr(ctx, REG_THRESHOLD);
            if ($urandom_range(0, 9) < 7) item.write_data = $urandom_range(0, 2);
        end else if (pick < 78) begin
            item.operation = OP_READ;
            item.address   = context_addr(ctx, REG_CLAIM);
        end else if (pick < 91) begin
            item.operation = OP_WRITE;
            if ((claim_word & LIVE_MASK) != 0 && $urandom_range(0, 4) != 0) begin
                // complete a source that is really claimed, preferring a context that has it enabled
                do begin
                    src = $urandom_range(1, SOURCES - 1);
                end while (!claim_word[src]);
                ctx = $urandom_range(0, CONTEXTS - 1);
                if (!enable_word[ctx][src]) ctx = (ctx + 1) % CONTEXTS;
                item.write_data = src;
            end else if ($urandom_range(0, 2) != 0) begin
                item.write_data = $urandom_range(0, SOURCES - 1);
            end
            item.address = context_addr(ctx, REG_CLAIM);
        end else begin
            item.operation = 2'($urandom_range(0, 3));
        end

        // misalign some accesses; the low address bits must be ignored
        if ($urandom_range(0, 7) == 0) item.address[1:0] = 2'($urandom_range(0, 3));
        return item;
    endfunction

    task automatic add_row(input logic [1:0] op, input logic [25:0] addr,
                           input logic [31:0] wdata, input logic [31:0] req,
                           input bit fixed, input logic [31:0] rdata, input logic [1:0] irq);
        directed_case_t row;
        row.stim.operation             = op;
        row.stim.address               = addr;
        row.stim.write_data            = wdata;
        row.stim.request_lines         = req;
        row.fixed                      = fixed;
        row.resp.read_data             = rdata;
        row.resp.context_interrupt     = irq;
        directed_cases.push_back(row);
    endtask

    // Hold the transaction until accepted, then record its expected response
    task automatic offer_transaction(input plic_in_t item, input bit fixed,
                                     input plic_out_t fixed_resp);
        plic_out_t resp;
        s_valid <= 1'b1;
        s_data  <= item;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        resp = predict_response(item);
        expected_responses.push_back(fixed ? fixed_resp : resp);
    endtask

    // Compare each accepted response with the oldest expectation
    always @(posedge aclk) begin : check_responses
        plic_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_responses.size() == 0) begin
                $display("%0t: unexpected response read_data %h context_interrupt %b",
                         $time, m_data.read_data, m_data.context_interrupt);
                error_count++;
            end else begin
                want = expected_responses.pop_front();
                if (m_data.read_data !== want.read_data) begin
                    $display("%0t: read_data expected %h, got %h",
                             $time, want.read_data, m_data.read_data);
                    error_count++;
                end
                if (m_data.context_interrupt !== want.context_interrupt) begin
                    $display("%0t: context_interrupt expected %b, got %b",
                             $time, want.context_interrupt, m_data.context_interrupt);
                    error_count++;
                end
            end
        end
    end

    // Stall the result channel in spans of varying style; honor one long hold-off
    initial begin : result_sink
        int unsigned style;
        int unsigned span;
        @(posedge aclk);
        forever begin
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
            style = $urandom_range(0, 3);
            span  = $urandom_range(1, 60);
            repeat (span) begin
                case (style)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= ($urandom_range(0, 1) == 1);
                    2:       m_ready <= ($urandom_range(0, 7) != 0);
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    // End the run when no transaction moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("platform_interrupt_controller_unit_test: errors");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int unsigned burst_left;
        int unsigned gap;

        // clear the state copy to its reset values
        for (int s = 0; s < SOURCES; s++) prio_tab[s] = '0;
        for (int c = 0; c < CONTEXTS; c++) begin
            enable_word[c] = '0;
            thr_tab[c]     = '0;
        end
        pend_word  = '0;
        claim_word = '0;

        // reset and directed rows: fixed expectations only where they are obvious
        add_row(OP_READ,   priority_addr(1),     32'h0,         32'h0, 1, 32'h0, 2'b00);
        add_row(OP_READ,   PEND_BASE,            32'h0,         32'h0, 1, 32'h0, 2'b00);
        add_row(OP_WRITE,  priority_addr(0),     32'hFFFF_FFFF, 32'h0, 1, 32'h0, 2'b00);
        add_row(OP_READ,   priority_addr(0),     32'h0,         32'h0, 1, 32'h0, 2'b00);
        add_row(OP_WRITE,  priority_addr(5),     32'hFFFF_FFFF, 32'h0, 1, 32'h0, 2'b00);
        add_row(OP_READ,   priority_addr(5),     32'h0,         32'h0, 1, PRIO_MAX, 2'b00);
        add_row(OP_WRITE,  PEND_BASE,            32'hFFFF_FFFF, 32'h0, 1, 32'h0, 2'b00);
        add_row(OP_WRITE,  enable_addr(0, 0),    32'hFFFF_FFFF, 32'h0, 1, 32'h0, 2'b00);
        add_row(OP_READ,   enable_addr(0, 0),    32'h0,         32'h0, 1, LIVE_MASK, 2'b00);
        add_row(OP_SAMPLE, 26'h0,                32'h0, 32'hFFFF_FFFF, 0, 32'h0, 2'b00);
        add_row(OP_READ,   PEND_BASE,            32'h0,         32'h0, 0, 32'h0, 2'b00);
        add_row(OP_WRITE,  priority_addr(9),     PRIO_MAX,      32'h0, 0, 32'h0, 2'b00);
        add_row(OP_READ,   context_addr(0, REG_CLAIM), 32'h0,   32'h0, 0, 32'h0, 2'b00);
        add_row(OP_READ,   context_addr(0, REG_CLAIM), 32'h0,   32'h0, 0, 32'h0, 2'b00);
        add_row(OP_READ,   context_addr(0, REG_CLAIM), 32'h0,   32'h0, 0, 32'h0, 2'b00);
        add_row(OP_WRITE,  context_addr(0, REG_CLAIM), 32'h0,   32'h0, 0, 32'h0, 2'b00);
        add_row(OP_WRITE,  context_addr(1, REG_CLAIM), 32'd5,   32'h0, 0, 32'h0, 2'b00);
        add_row(OP_WRITE,  context_addr(0, REG_CLAIM), 32'd5,   32'h0, 0, 32'h0, 2'b00);
        add_row(OP_SAMPLE, 26'h0,                32'h0,  32'h0000_0020, 0, 32'h0, 2'b00);
        add_row(OP_WRITE,  context_addr(0, REG_THRESHOLD), 32'hFFFF_FFFF, 32'h0, 0, 32'h0, 2'b00);
        add_row(OP_READ,   context_addr(0, REG_THRESHOLD) | 26'd3, 32'h0, 32'h0, 0, 32'h0, 2'b00);
        add_row(OP_READ,   context_addr(0, REG_CLAIM), 32'h0,   32'h0, 0, 32'h0, 2'b00);
        add_row(OP_SPARE,  context_addr(0, REG_CLAIM), 32'h0, 32'hFFFF_FFFF, 0, 32'h0, 2'b00);
        add_row(OP_READ,   context_addr(CONTEXTS, REG_CLAIM), 32'h0, 32'h0, 0, 32'h0, 2'b00);
        add_row(OP_READ,   26'h3FF_FFFC,         32'h0,         32'h0, 0, 32'h0, 2'b00);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_cases[i]) begin
            offer_transaction(directed_cases[i].stim, directed_cases[i].fixed,
                              directed_cases[i].resp);
        end

        // open with a long receiver hold-off while the sender keeps offering
        hold_off_pending = 1'b1;
        burst_left       = 60;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
                if (gap != 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                burst_left = $urandom_range(1, 40);
            end
            burst_left--;
            offer_transaction(random_item(), 1'b0, '0);
        end
        s_valid <= 1'b0;

        // drain outstanding responses, then allow stray ones to show up
        while (expected_responses.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("platform_interrupt_controller_unit_test: clean");
        end else begin
            $display("platform_interrupt_controller_unit_test: errors");
        end
        $finish;
    end

endmodule
